>>> rtl/crb_pkg.sv
// shared types and constants of the chunk reassembly buffer
`timescale 1ns / 1ps
`default_nettype none

package crb_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [1:0] {
    POS_HEADER  = 2'd0,
    POS_SEQ     = 2'd1,
    POS_PAYLOAD = 2'd2
  } pos_t;

  typedef struct packed {
    logic overflow;
    logic order;
    logic dropped;
  } flags_t;

  typedef struct packed {
    logic             packet_ready;
    logic [LEN_W-1:0] packet_length;
    logic             packet_dropped;
    logic             out_of_order;
    logic             overflow;
  } rpt_t;

  typedef struct packed {
    logic              do_write;
    logic              do_read;
    logic [BYTE_W-1:0] wr_data;
    rpt_t              rpt;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/chunk_reassembly_buffer_top.sv
// top level of the chunk reassembly buffer
// usage:
//   in_ channel: one request per accepted cycle (in_valid high, in_stall low).
//   in_req_type 0 carries one chunk byte (header, sequence, then payload) with
//   in_chunk_end on the last byte; in_req_type 1 reads the stored byte at
//   in_read_index.
//   out_ channel: exactly one result per request, in request order. chunk
//   bytes that do not end a chunk give an all-zero result; a chunk end gives
//   the packet ready, length and the chunk's flags; a read gives read_data.
//   each accepted request passes through the queue and then the output register
//   before its result is presented.
//   throughput: one request per cycle, sustained, while out_stall is low.
//   the front end updates chunk state as the request is accepted and queues a
//   buffer command; the back end performs the single-port buffer access and
//   registers the result. a four-entry queue decouples the two, so in_stall
//   rises only once the queue fills under a stalled output.
//   reset (rst_n low, synchronous): chunk state, queue and output valid are
//   cleared; buffer contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module chunk_reassembly_buffer_top #(
  parameter int unsigned BUF_DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_req_type,
  input  wire logic [crb_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic                        in_chunk_end,
  input  wire logic [crb_pkg::BYTE_W-1:0]  in_read_index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_packet_ready,
  output logic [crb_pkg::LEN_W-1:0]        out_packet_length,
  output logic                             out_packet_dropped,
  output logic                             out_out_of_order,
  output logic                             out_overflow,
  output logic [crb_pkg::BYTE_W-1:0]       out_read_data
);

  localparam int unsigned AW = $clog2(BUF_DEPTH);
  localparam int unsigned QW = $bits(crb_pkg::cmd_t) + AW;

  logic               acc;
  logic               q_full, q_empty, q_pop;
  crb_pkg::cmd_t      f_cmd, q_cmd;
  logic [AW-1:0]      f_addr, q_addr;
  logic [QW-1:0]      q_out;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  crb_front #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .req_type   (in_req_type),
    .data_byte  (in_data_byte),
    .chunk_end  (in_chunk_end),
    .read_index (in_read_index),
    .cmd        (f_cmd),
    .addr       (f_addr)
  );

  crb_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_data ({f_cmd, f_addr}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  assign q_cmd  = q_out[QW-1:AW];
  assign q_addr = q_out[AW-1:0];

  crb_back #(
    .BUF_DEPTH (BUF_DEPTH),
    .AW        (AW)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_cmd              (q_cmd),
    .q_addr             (q_addr),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_packet_ready   (out_packet_ready),
    .out_packet_length  (out_packet_length),
    .out_packet_dropped (out_packet_dropped),
    .out_out_of_order   (out_out_of_order),
    .out_overflow       (out_overflow),
    .out_read_data      (out_read_data)
  );

endmodule

`default_nettype wire

>>> rtl/crb_front.sv
// front end: chunk header and sequence tracking, turns requests into buffer commands
`timescale 1ns / 1ps
`default_nettype none

module crb_front #(
  parameter int unsigned BUF_DEPTH = 256,
  parameter int unsigned AW        = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        acc,
  input  wire logic                        req_type,
  input  wire logic [crb_pkg::BYTE_W-1:0]  data_byte,
  input  wire logic                        chunk_end,
  input  wire logic [crb_pkg::BYTE_W-1:0]  read_index,
  output crb_pkg::cmd_t                    cmd,
  output logic [AW-1:0]                    addr
);

  localparam int unsigned WPW = AW + 1;
  localparam int unsigned IW  = (AW > crb_pkg::BYTE_W) ? AW : crb_pkg::BYTE_W;
  localparam int unsigned EW  = (WPW > crb_pkg::LEN_W) ? WPW : crb_pkg::LEN_W;

  crb_pkg::pos_t                pos_r, pos_nxt;
  logic [WPW-1:0]               wp_r, wp_nxt;
  logic [crb_pkg::COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         accepted_r, accepted_nxt;
  crb_pkg::flags_t              flags_r, flags_nxt;
  logic [IW-1:0]                idx_ext;
  logic [EW-1:0]                wp_ext;

  assign idx_ext = IW'(read_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= crb_pkg::POS_HEADER;
      wp_r       <= '0;
      cnt_r      <= '0;
      accepted_r <= 1'b0;
      flags_r    <= '0;
    end else if (acc) begin
      pos_r      <= pos_nxt;
      wp_r       <= wp_nxt;
      cnt_r      <= cnt_nxt;
      accepted_r <= accepted_nxt;
      flags_r    <= flags_nxt;
    end
  end

  always_comb begin
    pos_nxt      = pos_r;
    wp_nxt       = wp_r;
    cnt_nxt      = cnt_r;
    accepted_nxt = accepted_r;
    flags_nxt    = flags_r;
    wp_ext       = '0;
    cmd          = '0;
    addr         = '0;
    if (req_type) begin
      cmd.do_read = (32'(read_index) < 32'(BUF_DEPTH));
      addr        = idx_ext[AW-1:0];
    end else begin
      unique case (pos_r)
        crb_pkg::POS_HEADER: begin
          flags_nxt    = '0;
          accepted_nxt = 1'b0;
          if (data_byte[crb_pkg::BYTE_W-1]) begin
            if (wp_r != '0) flags_nxt.dropped = 1'b1;
            wp_nxt  = '0;
            cnt_nxt = data_byte[crb_pkg::COUNT_W-1:0];
          end
          if (cnt_nxt != '0) cnt_nxt = cnt_nxt - crb_pkg::COUNT_W'(1);
          pos_nxt = crb_pkg::POS_SEQ;
        end
        crb_pkg::POS_SEQ: begin
          if (data_byte == {1'b0, cnt_r}) begin
            accepted_nxt = 1'b1;
          end else begin
            accepted_nxt    = 1'b0;
            flags_nxt.order = 1'b1;
          end
          pos_nxt = crb_pkg::POS_PAYLOAD;
        end
        crb_pkg::POS_PAYLOAD: begin
          if (accepted_r) begin
            if (wp_r < WPW'(BUF_DEPTH)) begin
              cmd.do_write = 1'b1;
              cmd.wr_data  = data_byte;
              addr         = wp_r[AW-1:0];
              wp_nxt       = wp_r + WPW'(1);
            end else begin
              flags_nxt.overflow = 1'b1;
            end
          end
        end
        default: pos_nxt = crb_pkg::POS_HEADER;
      endcase
      if (chunk_end) begin
        // header byte that also ends the chunk has no sequence byte
        if (pos_r == crb_pkg::POS_HEADER) flags_nxt.order = 1'b1;
        if (cnt_nxt == '0) begin
          wp_ext                = EW'(wp_nxt);
          cmd.rpt.packet_ready  = 1'b1;
          cmd.rpt.packet_length = wp_ext[crb_pkg::LEN_W-1:0];
          wp_nxt                = '0;
        end
        cmd.rpt.packet_dropped = flags_nxt.dropped;
        cmd.rpt.out_of_order   = flags_nxt.order;
        cmd.rpt.overflow       = flags_nxt.overflow;
        pos_nxt                = crb_pkg::POS_HEADER;
        accepted_nxt           = 1'b0;
        flags_nxt              = '0;
      end
    end
  end

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= WPW'(BUF_DEPTH))
    else $error("write position beyond buffer");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !req_type && chunk_end) |=> (pos_r == crb_pkg::POS_HEADER && flags_r == '0))
    else $error("chunk end did not restart chunk tracking");

endmodule

`default_nettype wire

>>> rtl/crb_queue.sv
// small command queue between the front end and the buffer back end
`timescale 1ns / 1ps
`default_nettype none

module crb_queue #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              empty
);

  logic [W-1:0]                 slot_r [crb_pkg::QUEUE_DEPTH];
  logic [crb_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [crb_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                         do_push, do_pop;

  assign full     = (count_r == crb_pkg::QCNT_W'(crb_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + crb_pkg::QCNT_W'(1);
    if (!do_push && do_pop) count_nxt = count_r - crb_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + crb_pkg::QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + crb_pkg::QPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= crb_pkg::QCNT_W'(crb_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == crb_pkg::QCNT_W'(crb_pkg::QUEUE_DEPTH))
      |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/crb_back.sv
// back end: packet buffer memory and registered result stage
`timescale 1ns / 1ps
`default_nettype none

module crb_back #(
  parameter int unsigned BUF_DEPTH = 256,
  parameter int unsigned AW        = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_empty,
  input  wire crb_pkg::cmd_t               q_cmd,
  input  wire logic [AW-1:0]               q_addr,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_packet_ready,
  output logic [crb_pkg::LEN_W-1:0]        out_packet_length,
  output logic                             out_packet_dropped,
  output logic                             out_out_of_order,
  output logic                             out_overflow,
  output logic [crb_pkg::BYTE_W-1:0]       out_read_data
);

  logic [crb_pkg::BYTE_W-1:0] mem [BUF_DEPTH];
  logic                       valid_r;
  crb_pkg::rpt_t              rpt_r;
  logic                       rd_sel_r;
  logic [crb_pkg::BYTE_W-1:0] rd_data_r;

  assign pop = !q_empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rpt_r    <= q_cmd.rpt;
      rd_sel_r <= q_cmd.do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.do_write) mem[q_addr] <= q_cmd.wr_data;
    if (pop && q_cmd.do_read)  rd_data_r   <= mem[q_addr];
  end

  assign out_valid          = valid_r;
  assign out_packet_ready   = rpt_r.packet_ready;
  assign out_packet_length  = rpt_r.packet_length;
  assign out_packet_dropped = rpt_r.packet_dropped;
  assign out_out_of_order   = rpt_r.out_of_order;
  assign out_overflow       = rpt_r.overflow;
  assign out_read_data      = rd_sel_r ? rd_data_r : '0;

  a_read_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && rd_sel_r) |-> (!rpt_r.packet_ready && !rpt_r.out_of_order))
    else $error("read result carries chunk report");

endmodule

`default_nettype wire

>>> tb/sv/chunk_reassembly_buffer_top_tb.sv
// self-checking testbench of the chunk reassembly buffer top level
`timescale 1ns / 1ps

module chunk_reassembly_buffer_top_tb;

  localparam int unsigned MEM_DEPTH  = 256;
  localparam logic REQ_CHUNK         = 1'b0;
  localparam logic REQ_READ          = 1'b1;
  localparam logic [7:0] FIRST_CHUNK = 8'h80;
  localparam logic [7:0] COUNT_MASK  = 8'h7f;
  localparam int RAND_ITEMS          = 750;
  localparam int HOLD_AFTER          = 400;
  localparam int HOLD_CYCLES         = 150;
  localparam int PAUSE_AFTER         = 500;
  localparam int IDLE_LIMIT          = 1000;
  localparam int TAIL_CYCLES         = 8;

  typedef struct packed {
    logic                       rd;
    logic [crb_pkg::BYTE_W-1:0] data;
    logic                       last;
    logic [crb_pkg::BYTE_W-1:0] idx;
  } req_t;

  typedef struct packed {
    logic                       ready;
    logic [crb_pkg::LEN_W-1:0]  length;
    logic                       dropped;
    logic                       order;
    logic                       ovf;
    logic [crb_pkg::BYTE_W-1:0] rdata;
  } result_t;

  typedef struct packed {
    req_t    r;
    logic    typed;
    result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_req_type;
  logic [crb_pkg::BYTE_W-1:0] in_data_byte;
  logic in_chunk_end;
  logic [crb_pkg::BYTE_W-1:0] in_read_index;
  logic out_valid;
  logic out_stall;
  logic out_packet_ready;
  logic [crb_pkg::LEN_W-1:0] out_packet_length;
  logic out_packet_dropped;
  logic out_out_of_order;
  logic out_overflow;
  logic [crb_pkg::BYTE_W-1:0] out_read_data;

  logic [crb_pkg::BYTE_W-1:0] pkt_mem [MEM_DEPTH];
  int     wr_pos = 0;
  int     filled = 0;
  logic [crb_pkg::COUNT_W-1:0] remaining = '0;
  crb_pkg::pos_t   byte_pos = crb_pkg::POS_HEADER;
  logic            chunk_ok = 1'b0;
  crb_pkg::flags_t chunk_flg = '0;

  result_t pending_results[$];
  int items_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int stall_left = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  chunk_reassembly_buffer_top #(
    .BUF_DEPTH(MEM_DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_data_byte      (in_data_byte),
    .in_chunk_end      (in_chunk_end),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packet_ready  (out_packet_ready),
    .out_packet_length (out_packet_length),
    .out_packet_dropped(out_packet_dropped),
    .out_out_of_order  (out_out_of_order),
    .out_overflow      (out_overflow),
    .out_read_data     (out_read_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t reassemble(input req_t r);
    result_t res;
    res = '0;
    if (r.rd == REQ_READ) begin
      res.rdata = pkt_mem[r.idx];
      return res;
    end
    case (byte_pos)
      crb_pkg::POS_HEADER: begin
        chunk_flg = '0;
        chunk_ok  = 1'b0;
        if ((r.data & FIRST_CHUNK) != 0) begin
          if (wr_pos > 0) chunk_flg.dropped = 1'b1;
          wr_pos    = 0;
          remaining = crb_pkg::COUNT_W'(r.data & COUNT_MASK);
        end
        if (remaining > 0) remaining = remaining - 1'b1;
        byte_pos = crb_pkg::POS_SEQ;
      end
      crb_pkg::POS_SEQ: begin
        chunk_ok = (r.data == {1'b0, remaining});
        if (!chunk_ok) chunk_flg.order = 1'b1;
        byte_pos = crb_pkg::POS_PAYLOAD;
      end
      default: begin
        if (chunk_ok) begin
          if (wr_pos < MEM_DEPTH) begin
            pkt_mem[wr_pos] = r.data;
            wr_pos++;
            if (wr_pos > filled) filled = wr_pos;
          end else begin
            chunk_flg.overflow = 1'b1;
          end
        end
      end
    endcase
    if (r.last) begin
      if (byte_pos == crb_pkg::POS_SEQ) chunk_flg.order = 1'b1;
      if (remaining == 0) begin
        res.ready  = 1'b1;
        res.length = wr_pos[crb_pkg::LEN_W-1:0];
        wr_pos     = 0;
      end
      res.dropped = chunk_flg.dropped;
      res.order   = chunk_flg.order;
      res.ovf     = chunk_flg.overflow;
      byte_pos    = crb_pkg::POS_HEADER;
      chunk_ok    = 1'b0;
      chunk_flg   = '0;
    end
    return res;
  endfunction

  function automatic dir_row_t row(input logic rd, input logic [7:0] data, input logic last,
                                   input logic [7:0] idx, input logic typed,
                                   input result_t res);
    dir_row_t d;
    d.r     = '{rd, data, last, idx};
    d.typed = typed;
    d.res   = res;
    return d;
  endfunction

  task automatic send_req(input req_t r, input bit fixed, input result_t fixed_res);
    int gap;
    result_t predicted;
    if ($urandom_range(39, 0) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(9, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= r.rd;
    in_data_byte  <= r.data;
    in_chunk_end  <= r.last;
    in_read_index <= r.idx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = reassemble(r);
    pending_results.push_back(fixed ? fixed_res : predicted);
    items_sent++;
  endtask

  task automatic send_read(input logic [7:0] idx);
    send_req('{REQ_READ, 8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)), idx},
             1'b0, '0);
  endtask

  task automatic send_byte(input logic [7:0] data, input logic last);
    if (filled > 0 && $urandom_range(7, 0) == 0) send_read(8'($urandom_range(filled - 1, 0)));
    send_req('{REQ_CHUNK, data, last, 8'($urandom_range(255, 0))}, 1'b0, '0);
  endtask

  task automatic send_chunk(input logic [7:0] hdr, input logic [7:0] seq, input int npay);
    send_byte(hdr, 1'b0);
    send_byte(seq, npay == 0);
    for (int i = 0; i < npay; i++) send_byte(8'($urandom_range(255, 0)), i == npay - 1);
  endtask

  task automatic send_packet(input int n, input int lo, input int hi);
    int cnt;
    cnt = (n > 0) ? n - 1 : 0;
    send_chunk(FIRST_CHUNK | 8'(n), 8'(cnt), $urandom_range(hi, lo));
    while (cnt > 0) begin
      cnt--;
      send_chunk(8'($urandom_range(127, 0)), 8'(cnt), $urandom_range(hi, lo));
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input result_t e, input result_t g);
    mismatches++;
    if (mismatches <= 10)
      $display({"%0t %s: exp rdy=%0d len=%0d drop=%0d ooo=%0d ovf=%0d rd=%02h",
                " | got rdy=%0d len=%0d drop=%0d ooo=%0d ovf=%0d rd=%02h"},
               $time, what, e.ready, e.length, e.dropped, e.order, e.ovf, e.rdata,
               g.ready, g.length, g.dropped, g.order, g.ovf, g.rdata);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_packet_ready, out_packet_length, out_packet_dropped,
             out_out_of_order, out_overflow, out_read_data};
      results_seen++;
      if ($urandom_range(39, 0) == 0) out_burst = !out_burst;
      stall_left = out_burst ? 0 : $urandom_range(9, 0);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) report_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_tab[$];
    int sel;
    int k;
    int n;
    bit paused;
    paused        = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_CHUNK;
    in_data_byte  = '0;
    in_chunk_end  = 1'b0;
    in_read_index = '0;

    // new packet of one chunk, two payload bytes at the value extremes
    dir_tab.push_back(row(REQ_CHUNK, 8'h80, 1'b0, 8'h00, 1'b1, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h00, 1'b0, 8'h00, 1'b1, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'hff, 1'b0, 8'hff, 1'b1, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h00, 1'b1, 8'h00, 1'b1,
                          '{1'b1, 9'd2, 1'b0, 1'b0, 1'b0, 8'h00}));
    dir_tab.push_back(row(REQ_READ, 8'h00, 1'b0, 8'h00, 1'b1,
                          '{1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 8'hff}));
    dir_tab.push_back(row(REQ_READ, 8'hff, 1'b1, 8'h01, 1'b1, '0));
    // first of two chunks, then a new packet discards it
    dir_tab.push_back(row(REQ_CHUNK, 8'h82, 1'b0, 8'h00, 1'b1, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h01, 1'b0, 8'h00, 1'b1, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'ha5, 1'b1, 8'h00, 1'b1, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h85, 1'b0, 8'h00, 1'b1, '0));
    // sequence byte with top bit set
    dir_tab.push_back(row(REQ_CHUNK, 8'h84, 1'b0, 8'h00, 1'b1, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h12, 1'b1, 8'h00, 1'b1,
                          '{1'b0, 9'd0, 1'b1, 1'b1, 1'b0, 8'h00}));
    // chunk ends on its header
    dir_tab.push_back(row(REQ_CHUNK, 8'h03, 1'b1, 8'h00, 1'b1,
                          '{1'b0, 9'd0, 1'b0, 1'b1, 1'b0, 8'h00}));
    dir_tab.push_back(row(REQ_CHUNK, 8'h7f, 1'b0, 8'h00, 1'b0, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h02, 1'b1, 8'h00, 1'b0, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h00, 1'b0, 8'h00, 1'b0, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h01, 1'b1, 8'h00, 1'b0, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h00, 1'b0, 8'h00, 1'b0, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h00, 1'b0, 8'h00, 1'b0, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'h77, 1'b1, 8'h00, 1'b1,
                          '{1'b1, 9'd1, 1'b0, 1'b0, 1'b0, 8'h00}));
    dir_tab.push_back(row(REQ_READ, 8'h00, 1'b0, 8'h00, 1'b1,
                          '{1'b0, 9'd0, 1'b0, 1'b0, 1'b0, 8'h77}));
    dir_tab.push_back(row(REQ_READ, 8'h00, 1'b0, 8'h01, 1'b0, '0));
    dir_tab.push_back(row(REQ_CHUNK, 8'hff, 1'b1, 8'h00, 1'b0, '0));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i].r, dir_tab[i].typed, dir_tab[i].res);

    // fill the buffer past its end
    send_packet(0, 258, 266);
    send_read(8'hff);
    send_read(8'h00);

    while (items_sent < RAND_ITEMS) begin
      if (!paused && items_sent >= PAUSE_AFTER) begin
        paused = 1'b1;
        wait_drained();
      end
      sel = $urandom_range(99, 0);
      if (sel < 55) begin
        send_packet($urandom_range(4, 0), 0, 6);
      end else if (sel < 60) begin
        send_chunk(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                   $urandom_range(4, 0));
      end else if (sel < 64) begin
        send_byte(8'($urandom_range(255, 0)), 1'b1);
      end else if (sel < 71) begin
        n = $urandom_range(5, 2);
        send_chunk(FIRST_CHUNK | 8'(n), 8'(n - 1), $urandom_range(4, 1));
        send_packet($urandom_range(3, 0), 0, 4);
      end else if (sel < 82) begin
        k = $urandom_range(8, 1);
        for (int i = 0; i < k; i++)
          send_byte(8'($urandom_range(255, 0)), i == k - 1 || $urandom_range(3, 0) == 0);
      end else if (sel < 93) begin
        k = $urandom_range(6, 1);
        for (int i = 0; i < k; i++) send_read(8'($urandom_range(filled - 1, 0)));
      end else if (sel < 94) begin
        send_packet(0, 256, 262);
      end else if (sel < 97) begin
        wait_drained();
      end else begin
        send_packet($urandom_range(127, 5), 0, 1);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
